### sv/gdd_pkg.sv
`timescale 1ns / 1ps

package gdd_pkg;

  // Field widths of the request and the response.
  localparam int DayW    = 5;
  localparam int MonthW  = 4;
  localparam int YearW   = 14;
  localparam int StatusW = 2;
  localparam int DiffW   = 22;

  // A day number for any 14-bit year stays below 2^23.
  localparam int DayNumW = 23;

  // Highest year that counts as valid.
  localparam int MaxYear = 9999;

  // Division by 100 as a multiplication by a scaled reciprocal. The quotient is
  // exact for every dividend below 43690, so it covers the whole year field.
  localparam int            RecipShift = 19;
  localparam int            RecipW     = 13;
  localparam logic [12:0]   Recip100   = 13'd5243;
  localparam int            ProdW      = YearW + RecipW;
  localparam int            QuotW      = ProdW - RecipShift;

  localparam int DaysPerYear = 365;
  localparam int MonthsPerYr = 12;

  typedef enum logic [StatusW-1:0] {
    STATUS_OK         = 2'd0,
    STATUS_FIRST_BAD  = 2'd1,
    STATUS_SECOND_BAD = 2'd2,
    STATUS_REVERSED   = 2'd3
  } gdd_status_e;

  // Pipeline control that the merge stage needs from the top level.
  typedef struct packed {
    logic advance;
    logic last_vld;
  } gdd_ctrl_t;

  // What one lane hands to the merge stage.
  typedef struct packed {
    logic               date_ok;
    logic [DayNumW-1:0] day_num;
  } gdd_lane_t;

  function automatic logic [DayW-1:0] month_days(input logic [MonthW-1:0] month,
                                                  input logic leap);
    logic [DayW-1:0] len;
    case (month)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  // Days in the months of a common year that come before the given month.
  function automatic logic [8:0] days_before(input logic [MonthW-1:0] month);
    logic [8:0] days;
    case (month)
      4'd1:    days = 9'd0;
      4'd2:    days = 9'd31;
      4'd3:    days = 9'd59;
      4'd4:    days = 9'd90;
      4'd5:    days = 9'd120;
      4'd6:    days = 9'd151;
      4'd7:    days = 9'd181;
      4'd8:    days = 9'd212;
      4'd9:    days = 9'd243;
      4'd10:   days = 9'd273;
      4'd11:   days = 9'd304;
      4'd12:   days = 9'd334;
      default: days = 9'd0;
    endcase
    return days;
  endfunction

endpackage

### sv/gdd_req_if.sv
`timescale 1ns / 1ps

interface gdd_req_if import gdd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DayW-1:0]   first_day;
  logic [MonthW-1:0] first_month;
  logic [YearW-1:0]  first_year;
  logic [DayW-1:0]   second_day;
  logic [MonthW-1:0] second_month;
  logic [YearW-1:0]  second_year;

  modport source (
    output valid, first_day, first_month, first_year,
           second_day, second_month, second_year,
    input  ready
  );

  modport sink (
    input  valid, first_day, first_month, first_year,
           second_day, second_month, second_year,
    output ready
  );
endinterface

### sv/gdd_rsp_if.sv
`timescale 1ns / 1ps

interface gdd_rsp_if import gdd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [StatusW-1:0] status;
  logic [DiffW-1:0]   day_difference;

  modport source (
    output valid, status, day_difference,
    input  ready
  );

  modport sink (
    input  valid, status, day_difference,
    output ready
  );
endinterface

### sv/gdd_lane.sv
`timescale 1ns / 1ps

module gdd_lane import gdd_pkg::*; (
  input  logic              clk_i,
  input  logic              advance_i,
  input  logic [DayW-1:0]   day_i,
  input  logic [MonthW-1:0] month_i,
  input  logic [YearW-1:0]  year_i,
  output gdd_lane_t         res_o
);

  // Stage 1: the three constant products.
  logic [YearW-1:0]   year_m1;
  logic [ProdW-1:0]   yq_prod_d;
  logic [ProdW-1:0]   pq_prod_d;
  logic [DayNumW-1:0] p365_d;

  logic [DayW-1:0]    s1_day_q;
  logic [MonthW-1:0]  s1_month_q;
  logic [YearW-1:0]   s1_year_q;
  logic [ProdW-1:0]   s1_yq_prod_q;
  logic [ProdW-1:0]   s1_pq_prod_q;
  logic [DayNumW-1:0] s1_p365_q;

  assign year_m1   = year_i - YearW'(1);
  assign yq_prod_d = ProdW'(year_i) * ProdW'(Recip100);
  assign pq_prod_d = ProdW'(year_m1) * ProdW'(Recip100);
  assign p365_d    = DayNumW'(year_m1) * DayNumW'(DaysPerYear);

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      s1_day_q     <= day_i;
      s1_month_q   <= month_i;
      s1_year_q    <= year_i;
      s1_yq_prod_q <= yq_prod_d;
      s1_pq_prod_q <= pq_prod_d;
      s1_p365_q    <= p365_d;
    end
  end

  // Stage 2: leap year, validity and the day count of the elapsed years.
  logic [QuotW-1:0]   yq;
  logic [QuotW-1:0]   pq;
  logic [YearW-1:0]   yq_x100;
  logic [YearW-1:0]   s1_year_m1;
  logic               div_by_100;
  logic               leap_d;
  logic               ok_d;
  logic [DayNumW-1:0] base_d;

  logic [DayNumW-1:0] s2_base_q;
  logic [MonthW-1:0]  s2_month_q;
  logic [DayW-1:0]    s2_day_q;
  logic               s2_leap_q;
  logic               s2_ok_q;

  assign yq         = s1_yq_prod_q[RecipShift +: QuotW];
  assign pq         = s1_pq_prod_q[RecipShift +: QuotW];
  assign yq_x100    = YearW'(yq) * YearW'(100);
  assign div_by_100 = (yq_x100 == s1_year_q);
  assign s1_year_m1 = s1_year_q - YearW'(1);

  // A year divisible by 100 is a leap year only when its century count is
  // itself divisible by four.
  assign leap_d = ((s1_year_q[1:0] == 2'd0) && !div_by_100) ||
                  (div_by_100 && (yq[1:0] == 2'd0));

  assign ok_d = (s1_month_q >= MonthW'(1)) && (s1_month_q <= MonthW'(MonthsPerYr)) &&
                (s1_year_q  >= YearW'(1))  && (s1_year_q  <= YearW'(MaxYear)) &&
                (s1_day_q   >= DayW'(1))   &&
                (s1_day_q   <= month_days(s1_month_q, leap_d));

  assign base_d = s1_p365_q + DayNumW'(s1_year_m1 >> 2) - DayNumW'(pq) +
                  DayNumW'(pq >> 2);

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      s2_base_q  <= base_d;
      s2_month_q <= s1_month_q;
      s2_day_q   <= s1_day_q;
      s2_leap_q  <= leap_d;
      s2_ok_q    <= ok_d;
    end
  end

  // Stage 3: add the elapsed months, the leap day and the day of the month.
  logic      leap_add;
  gdd_lane_t res_d;
  gdd_lane_t res_q;

  assign leap_add        = s2_leap_q && (s2_month_q > MonthW'(2));
  assign res_d.date_ok   = s2_ok_q;
  assign res_d.day_num   = s2_base_q + DayNumW'(days_before(s2_month_q)) +
                           DayNumW'(leap_add) + DayNumW'(s2_day_q);

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

### sv/gdd_merge.sv
`timescale 1ns / 1ps

module gdd_merge import gdd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  gdd_ctrl_t        ctrl_i,
  input  gdd_lane_t        first_i,
  input  gdd_lane_t        second_i,
  output logic             vld_o,
  output gdd_status_e      status_o,
  output logic [DiffW-1:0] diff_o
);

  gdd_status_e      status_d;
  gdd_status_e      status_q;
  logic [DiffW-1:0] diff_d;
  logic [DiffW-1:0] diff_q;
  logic             vld_q;
  logic [DayNumW-1:0] span;

  assign span = second_i.day_num - first_i.day_num;

  // The first invalid date wins over everything else.
  always_comb begin
    diff_d = '0;
    if (!first_i.date_ok) begin
      status_d = STATUS_FIRST_BAD;
    end else if (!second_i.date_ok) begin
      status_d = STATUS_SECOND_BAD;
    end else if (second_i.day_num < first_i.day_num) begin
      status_d = STATUS_REVERSED;
    end else begin
      status_d = STATUS_OK;
      diff_d   = span[DiffW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ctrl_i.advance) begin
      vld_q <= ctrl_i.last_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.advance) begin
      status_q <= status_d;
      diff_q   <= diff_d;
    end
  end

  assign vld_o    = vld_q;
  assign status_o = status_q;
  assign diff_o   = diff_q;

endmodule

### sv/gregorian_date_difference_core.sv
`timescale 1ns / 1ps

// Day count between two Gregorian dates.
// A request on req_i carries two dates (day, month, year). The response on
// rsp_o carries a status and the number of days from the first date to the
// second. Status is OK when both dates are valid and the second is not
// earlier; otherwise it names the first invalid date or a reversed order,
// and the day difference is zero. Valid years run from 1 to 9999.
// Two identical lanes turn the two dates into day numbers in closed form,
// and a merge stage compares and subtracts them.
// A request passes through three lane stages and then one output register.
// Throughput is one request per cycle while the receiver does not stall,
// since every stage is a plain register stage.
// Reset empties the pipeline; req_i.ready is high right after reset.
// When the receiver stalls, the whole pipeline holds; up to four requests
// sit in flight, and req_i.ready stays high while the output register is
// empty or is being taken.
module gregorian_date_difference_core import gdd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  gdd_req_if.sink   req_i,
  gdd_rsp_if.source rsp_o
);

  // The pipeline moves as one: every stage advances unless the output
  // register holds a response that is not being taken.
  logic        out_vld;
  logic        advance;
  logic [2:0]  vld_q;
  logic [2:0]  vld_d;
  gdd_ctrl_t   ctrl;
  gdd_lane_t   first_res;
  gdd_lane_t   second_res;
  gdd_status_e status;
  logic [DiffW-1:0] diff;

  assign advance     = !out_vld || rsp_o.ready;
  assign req_i.ready = advance;

  assign vld_d = {vld_q[1:0], req_i.valid};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (advance) begin
      vld_q <= vld_d;
    end
  end

  assign ctrl.advance  = advance;
  assign ctrl.last_vld = vld_q[2];

  // One lane for each date of the request.
  gdd_lane u_lane_first (
    .clk_i     (clk_i),
    .advance_i (advance),
    .day_i     (req_i.first_day),
    .month_i   (req_i.first_month),
    .year_i    (req_i.first_year),
    .res_o     (first_res)
  );

  gdd_lane u_lane_second (
    .clk_i     (clk_i),
    .advance_i (advance),
    .day_i     (req_i.second_day),
    .month_i   (req_i.second_month),
    .year_i    (req_i.second_year),
    .res_o     (second_res)
  );

  // The merge stage holds the output register.
  gdd_merge u_merge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .first_i  (first_res),
    .second_i (second_res),
    .vld_o    (out_vld),
    .status_o (status),
    .diff_o   (diff)
  );

  assign rsp_o.valid          = out_vld;
  assign rsp_o.status         = status;
  assign rsp_o.day_difference = diff;

`ifndef SYNTHESIS
  // An accepted request enters the first lane stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> vld_q[0])
    else $error("accepted request did not enter the pipeline");

  // A stall freezes every stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> (vld_q == $past(vld_q)))
    else $error("pipeline moved during a stall");

  // A request leaving the last lane stage lands in the output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && vld_q[2]) |=> rsp_o.valid)
    else $error("request lost between lanes and output register");

  // Error responses carry no day count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && (rsp_o.status != STATUS_OK)) |-> (rsp_o.day_difference == '0))
    else $error("nonzero day difference with an error status");
`endif

endmodule
